// ===== rtl/rbfc_pkg.sv =====
// Shared types, field widths and codes for the range bounded frequency counter.
package rbfc_pkg;

  // Field widths of the input and result beats
  localparam int OP_W    = 2;
  localparam int ELEM_W  = 10;
  localparam int RANGE_W = 12;
  localparam int LIMIT_W = 13;
  localparam int COUNT_W = 13;

  typedef logic [OP_W-1:0] opcode_t;

  // Opcodes
  localparam opcode_t OP_LOAD    = 2'd0;
  localparam opcode_t OP_QUERY   = 2'd1;
  localparam opcode_t OP_RESTART = 2'd2;

  // Read address select for the count-histogram memory
  typedef logic [1:0] vac_sel_t;
  localparam vac_sel_t VA_STEP  = 2'd0;
  localparam vac_sel_t VA_ZERO  = 2'd1;
  localparam vac_sel_t VA_LIMIT = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic     capture;
    logic     restart;
    logic     clr_step;
    logic     div_step;
    logic     load_commit;
    logic     step_start;
    logic     elem_rd;
    logic     occ_rd;
    logic     occ_wr;
    logic     vac_rd;
    vac_sel_t vac_sel;
    logic     vac_wr;
    logic     total_cap;
    logic     out_load;
  } rbfc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    opcode_t opcode;
    logic    bad;
    logic    step_any;
    logic    div_last;
    logic    clr_last;
    logic    out_busy;
  } rbfc_sts_t;

endpackage

// ===== rtl/rbfc_if.sv =====
// Valid/ready channel interfaces for the input beats and the result beats.
interface rbfc_in_if;
  import rbfc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      opcode;
  logic [ELEM_W-1:0]    element_value;
  logic [RANGE_W-1:0]   range_left;
  logic [RANGE_W-1:0]   range_right;
  logic [LIMIT_W-1:0]   occurrence_limit;

  modport source (
    output valid, opcode, element_value, range_left, range_right, occurrence_limit,
    input  ready
  );
  modport sink (
    input  valid, opcode, element_value, range_left, range_right, occurrence_limit,
    output ready
  );
endinterface

interface rbfc_out_if;
  import rbfc_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] distinct_count;
  logic               bad_range;

  modport source (
    output valid, distinct_count, bad_range,
    input  ready
  );
  modport sink (
    input  valid, distinct_count, bad_range,
    output ready
  );
endinterface

// ===== rtl/rbfc_ctrl.sv =====
// Sequencer for loads, window steps, queries and the memory clearing pass.
module rbfc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output rbfc_pkg::rbfc_cmd_t cmd,
  input  rbfc_pkg::rbfc_sts_t sts
);
  import rbfc_pkg::*;

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DISPATCH = 4'd2;
  localparam logic [3:0] S_DIV      = 4'd3;
  localparam logic [3:0] S_LOAD     = 4'd4;
  localparam logic [3:0] S_SEL      = 4'd5;
  localparam logic [3:0] S_E_RD     = 4'd6;
  localparam logic [3:0] S_O_RD     = 4'd7;
  localparam logic [3:0] S_O_WR     = 4'd8;
  localparam logic [3:0] S_V_WR     = 4'd9;
  localparam logic [3:0] S_Q0       = 4'd10;
  localparam logic [3:0] S_Q1       = 4'd11;
  localparam logic [3:0] S_RESULT   = 4'd12;

  logic [3:0] state_r, state_nxt;

  // State register; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.opcode)
          OP_LOAD:    state_nxt = S_DIV;
          OP_QUERY:   state_nxt = sts.bad ? S_RESULT : S_SEL;
          OP_RESTART: begin
            cmd.restart = 1'b1;
            state_nxt   = S_CLEAR;
          end
          default:    state_nxt = S_IDLE;
        endcase
      end
      // value modulo VALUES: quotient first, remainder next
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_commit = 1'b1;
        state_nxt       = S_IDLE;
      end
      // pick the next window move, or finish
      S_SEL: begin
        cmd.step_start = 1'b1;
        state_nxt      = sts.step_any ? S_E_RD : S_Q0;
      end
      S_E_RD: begin
        cmd.elem_rd = 1'b1;
        state_nxt   = S_O_RD;
      end
      S_O_RD: begin
        cmd.occ_rd = 1'b1;
        state_nxt  = S_O_WR;
      end
      S_O_WR: begin
        cmd.occ_wr  = 1'b1;
        cmd.vac_rd  = 1'b1;
        cmd.vac_sel = VA_STEP;
        state_nxt   = S_V_WR;
      end
      S_V_WR: begin
        cmd.vac_wr = 1'b1;
        state_nxt  = S_SEL;
      end
      // answer: entry 0 minus entry limit
      S_Q0: begin
        cmd.vac_rd  = 1'b1;
        cmd.vac_sel = VA_ZERO;
        state_nxt   = S_Q1;
      end
      S_Q1: begin
        cmd.total_cap = 1'b1;
        cmd.vac_rd    = 1'b1;
        cmd.vac_sel   = VA_LIMIT;
        state_nxt     = S_RESULT;
      end
      S_RESULT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // A window step only starts when the datapath found a move
  a_step_has_move: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_E_RD |-> $past(sts.step_any))
    else $error("window step started with no move pending");

  // The clearing pass runs to its last entry
  a_clear_runs_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR && !sts.clr_last |=> state_r == S_CLEAR)
    else $error("clearing pass left early");

  // A result leaves as soon as the output register is free
  a_result_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RESULT && !sts.out_busy |=> state_r == S_IDLE)
    else $error("result not handed to output register");

endmodule

// ===== rtl/rbfc_dpath.sv =====
// Element store, occurrence and count-histogram memories, window pointers and result register.
module rbfc_dpath #(
  parameter int SIZE   = 4096,
  parameter int VALUES = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rbfc_pkg::rbfc_cmd_t            cmd,
  output rbfc_pkg::rbfc_sts_t            sts,
  input  logic [rbfc_pkg::OP_W-1:0]      in_opcode,
  input  logic [rbfc_pkg::ELEM_W-1:0]    in_element_value,
  input  logic [rbfc_pkg::RANGE_W-1:0]   in_range_left,
  input  logic [rbfc_pkg::RANGE_W-1:0]   in_range_right,
  input  logic [rbfc_pkg::LIMIT_W-1:0]   in_occurrence_limit,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rbfc_pkg::COUNT_W-1:0]   out_distinct_count,
  output logic                           out_bad_range
);
  import rbfc_pkg::*;

  localparam int IDX_W  = (SIZE > 1) ? $clog2(SIZE) : 1;
  localparam int VIDX_W = (VALUES > 1) ? $clog2(VALUES) : 1;
  localparam int CNT_W  = $clog2(SIZE + 1);
  localparam int CLR_N  = (SIZE > VALUES) ? SIZE : VALUES;
  localparam int CLR_W  = (CLR_N > 1) ? $clog2(CLR_N) : 1;
  // quotient by reciprocal: exact for every ELEM_W-bit value with this shift
  localparam int RCP_S  = 2 * ELEM_W;
  localparam logic [31:0] RCP_M = (VALUES >= (1 << ELEM_W)) ? 32'd0 :
                                  32'(((1 << RCP_S) + VALUES - 1) / VALUES);
  localparam logic [ELEM_W-1:0] VMOD = (VALUES >= (1 << ELEM_W)) ? '0 : ELEM_W'(VALUES);
  localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

  // Captured beat
  opcode_t             op_r;
  logic [ELEM_W-1:0]   val_r;
  logic [RANGE_W-1:0]  left_r, right_r;
  logic [LIMIT_W-1:0]  limit_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_opcode;
      val_r   <= in_element_value;
      left_r  <= in_range_left;
      right_r <= in_range_right;
      limit_r <= in_occurrence_limit;
    end
  end

  // Remainder of the loaded value by VALUES over two steps:
  // quotient by reciprocal multiply, then multiply back and subtract
  logic [ELEM_W-1:0]   quo_r, rem_r;
  logic                div_cnt_r;
  logic [31:0]         rcp_prod;
  logic [2*ELEM_W-1:0] quo_mul;

  assign rcp_prod = 32'(val_r) * RCP_M;
  assign quo_mul  = {{ELEM_W{1'b0}}, quo_r} * {{ELEM_W{1'b0}}, VMOD};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      div_cnt_r <= 1'b1;
    end else if (cmd.div_step) begin
      div_cnt_r <= 1'b0;
      if (div_cnt_r) begin
        quo_r <= rcp_prod[RCP_S +: ELEM_W];
      end else begin
        rem_r <= val_r - quo_mul[ELEM_W-1:0];
      end
    end
  end

  // Clearing pass counter
  logic [CLR_W-1:0] clr_cnt_r;
  logic [31:0]      clr32;
  logic             clr_last;

  assign clr32    = 32'(clr_cnt_r);
  assign clr_last = (clr32 == 32'(CLR_N - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_last ? '0 : clr_cnt_r + CLR_W'(1);
    end
  end

  // Window move selection
  logic [CNT_W-1:0] len_r, win_left_r, win_end_r;
  logic [CNT_W-1:0] pos_r, pos_nxt, wl_nxt, we_nxt;
  logic             grow_r, grow_nxt, step_any;
  logic [31:0]      wl32, we32, lt32, st32;

  assign wl32 = 32'(win_left_r);
  assign we32 = 32'(win_end_r);
  assign lt32 = 32'(left_r);
  assign st32 = 32'(right_r) + 32'd1;

  always_comb begin
    step_any = 1'b1;
    grow_nxt = 1'b1;
    pos_nxt  = win_left_r;
    wl_nxt   = win_left_r;
    we_nxt   = win_end_r;
    if (wl32 > lt32) begin
      pos_nxt = win_left_r - ONE_C;
      wl_nxt  = win_left_r - ONE_C;
    end else if (we32 < st32) begin
      pos_nxt = win_end_r;
      we_nxt  = win_end_r + ONE_C;
    end else if (wl32 < lt32) begin
      grow_nxt = 1'b0;
      pos_nxt  = win_left_r;
      wl_nxt   = win_left_r + ONE_C;
    end else if (we32 > st32) begin
      grow_nxt = 1'b0;
      pos_nxt  = win_end_r - ONE_C;
      we_nxt   = win_end_r - ONE_C;
    end else begin
      step_any = 1'b0;
    end
  end

  // Length and window registers
  logic load_room;
  assign load_room = (32'(len_r) < SIZE);

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.restart) begin
      len_r      <= '0;
      win_left_r <= '0;
      win_end_r  <= '0;
    end else begin
      if (cmd.load_commit && load_room) len_r <= len_r + ONE_C;
      if (cmd.step_start) begin
        win_left_r <= wl_nxt;
        win_end_r  <= we_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step_start) begin
      pos_r  <= pos_nxt;
      grow_r <= grow_nxt;
    end
  end

  // Element store
  logic [ELEM_W-1:0] elem_mem [SIZE];
  logic [ELEM_W-1:0] elem_rdata_r;
  logic [31:0]       len32, pos32;

  assign len32 = 32'(len_r);
  assign pos32 = 32'(pos_r);

  always_ff @(posedge clk) begin
    if (cmd.load_commit && load_room) elem_mem[len32[IDX_W-1:0]] <= rem_r;
    if (cmd.elem_rd) elem_rdata_r <= elem_mem[pos32[IDX_W-1:0]];
  end

  // Occurrence count per value
  logic [CNT_W-1:0]  occ_mem [VALUES];
  logic [CNT_W-1:0]  occ_rdata_r;
  logic [VIDX_W-1:0] occ_raddr, val_idx_r, occ_waddr;
  logic [CNT_W-1:0]  occ_wdata;
  logic              occ_we;
  logic [31:0]       elem32;

  assign elem32    = 32'(elem_rdata_r);
  assign occ_raddr = elem32[VIDX_W-1:0];

  // Step arithmetic on the old occurrence count
  logic [31:0]      b32, bm32;
  logic             vac_en_nxt, vac_en_r;
  logic [IDX_W-1:0] vac_idx_nxt, vac_idx_r;

  assign b32  = 32'(occ_rdata_r);
  assign bm32 = b32 - 32'd1;

  always_comb begin
    if (grow_r) begin
      vac_en_nxt  = (b32 < SIZE);
      vac_idx_nxt = b32[IDX_W-1:0];
    end else begin
      vac_en_nxt  = (b32 != 32'd0) && (bm32 < SIZE);
      vac_idx_nxt = bm32[IDX_W-1:0];
    end
  end

  always_comb begin
    occ_we    = 1'b0;
    occ_waddr = val_idx_r;
    occ_wdata = '0;
    if (cmd.clr_step) begin
      occ_we    = (clr32 < VALUES);
      occ_waddr = clr32[VIDX_W-1:0];
    end else if (cmd.occ_wr) begin
      occ_we    = grow_r || (b32 != 32'd0);
      occ_wdata = grow_r ? occ_rdata_r + ONE_C : occ_rdata_r - ONE_C;
    end
  end

  always_ff @(posedge clk) begin
    if (occ_we) occ_mem[occ_waddr] <= occ_wdata;
    if (cmd.occ_rd) occ_rdata_r <= occ_mem[occ_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.occ_rd) val_idx_r <= occ_raddr;
    if (cmd.occ_wr) begin
      vac_en_r  <= vac_en_nxt;
      vac_idx_r <= vac_idx_nxt;
    end
  end

  // Count histogram: entry k holds how many values occur more than k times
  logic [CNT_W-1:0] vac_mem [SIZE];
  logic [CNT_W-1:0] vac_rdata_r;
  logic [IDX_W-1:0] vac_raddr, vac_waddr;
  logic [CNT_W-1:0] vac_wdata;
  logic             vac_we;
  logic [31:0]      lim32;

  assign lim32 = 32'(limit_r);

  always_comb begin
    case (cmd.vac_sel)
      VA_STEP:  vac_raddr = vac_idx_nxt;
      VA_ZERO:  vac_raddr = '0;
      VA_LIMIT: vac_raddr = lim32[IDX_W-1:0];
      default:  vac_raddr = '0;
    endcase
  end

  always_comb begin
    vac_we    = 1'b0;
    vac_waddr = vac_idx_r;
    vac_wdata = '0;
    if (cmd.clr_step) begin
      vac_we    = (clr32 < SIZE);
      vac_waddr = clr32[IDX_W-1:0];
    end else if (cmd.vac_wr) begin
      vac_we    = vac_en_r && (grow_r || (vac_rdata_r != '0));
      vac_wdata = grow_r ? vac_rdata_r + ONE_C : vac_rdata_r - ONE_C;
    end
  end

  always_ff @(posedge clk) begin
    if (vac_we) vac_mem[vac_waddr] <= vac_wdata;
    if (cmd.vac_rd) vac_rdata_r <= vac_mem[vac_raddr];
  end

  // Answer
  logic [CNT_W-1:0] total_r, above, diff;
  logic [31:0]      diff32;
  logic             bad;

  always_ff @(posedge clk) begin
    if (cmd.total_cap) total_r <= vac_rdata_r;
  end

  assign bad    = (32'(left_r) > 32'(right_r)) || (32'(right_r) >= len32);
  assign above  = (lim32 < SIZE) ? vac_rdata_r : '0;
  assign diff   = total_r - above;
  assign diff32 = 32'(diff);

  // Output register
  logic               out_valid_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_count_r <= bad ? '0 : diff32[COUNT_W-1:0];
      out_bad_r   <= bad;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_distinct_count = out_count_r;
  assign out_bad_range      = out_bad_r;

  // Status to the controller
  always_comb begin
    sts          = '0;
    sts.opcode   = op_r;
    sts.bad      = bad;
    sts.step_any = step_any;
    sts.div_last = (div_cnt_r == 1'b0);
    sts.clr_last = clr_last;
    sts.out_busy = out_valid_r && !out_ready;
  end

  // Window stays inside the loaded elements
  a_window_in_length: assert property (@(posedge clk) disable iff (!rst_n)
    win_end_r <= len_r)
    else $error("window end beyond loaded length");

  // Window bounds stay ordered
  a_window_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    win_left_r <= win_end_r)
    else $error("window left above window end");

  // A result beat appears only when the controller loads one
  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.out_load))
    else $error("result beat without a load");

endmodule

// ===== rtl/range_bounded_frequency_counter.sv =====
// Top level of the range bounded frequency counter: controller plus datapath.
//
// Loads append elements (value taken modulo VALUES) to a store of SIZE entries; queries
// slide a window over the loaded elements and return how many distinct values in
// [range_left, range_right] occur between one and occurrence_limit times; a restart
// clears everything. One beat is worked at a time. A load works out the remainder
// (reciprocal multiply for the quotient, then multiply back and subtract) before it
// stores the element. A bad query leaves the window alone. A good query moves the
// window one element at a time, left and right edges alike; each move is a
// read-modify-write of the occurrence memory and then of the count-histogram memory.
// After reset and after a restart a clearing pass over max(SIZE, VALUES) entries
// zeroes both count memories and no beat is taken meanwhile. A finished result sits
// in an output register, so the next beat can be taken while it waits.
module range_bounded_frequency_counter #(
  parameter int SIZE   = 4096,
  parameter int VALUES = 1024
) (
  input logic  clk,
  input logic  rst_n,
  rbfc_in_if.sink    in_ch,
  rbfc_out_if.source out_ch
);
  import rbfc_pkg::*;

  rbfc_cmd_t cmd;
  rbfc_sts_t sts;

  rbfc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  rbfc_dpath #(
    .SIZE   (SIZE),
    .VALUES (VALUES)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_opcode           (in_ch.opcode),
    .in_element_value    (in_ch.element_value),
    .in_range_left       (in_ch.range_left),
    .in_range_right      (in_ch.range_right),
    .in_occurrence_limit (in_ch.occurrence_limit),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_distinct_count  (out_ch.distinct_count),
    .out_bad_range       (out_ch.bad_range)
  );

endmodule

// ===== dv/rbfc_tally_checker.sv =====
// Checker for the range bounded frequency counter: watches both channels, predicts and compares.
module rbfc_tally_checker #(
  parameter int SIZE   = 4096,
  parameter int VALUES = 1024
) (
  input  logic clk,
  input  logic rst_n,
  rbfc_in_if   in_mon,
  rbfc_out_if  out_mon,
  output int   pending,
  output int   failures
);
  timeunit 1ns;
  timeprecision 1ps;
  import rbfc_pkg::*;

  // One expected result beat
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               bad;
  } tally_t;

  // Predictor state: element store, per-value counts, per-count histogram, window
  logic [ELEM_W-1:0] elem_mem [SIZE];
  int unsigned       occ_of [VALUES];
  int unsigned       above_cnt [SIZE];
  int unsigned       stored_len;
  int unsigned       win_lo;
  int unsigned       win_hi;

  tally_t tallies_due [$];
  int     miss_total = 0;

  // Empty store, empty window, all counts zero
  function automatic void clear_model();
    for (int i = 0; i < SIZE; i++) begin
      elem_mem[i]  = '0;
      above_cnt[i] = 0;
    end
    for (int i = 0; i < VALUES; i++) occ_of[i] = 0;
    stored_len = 0;
    win_lo     = 0;
    win_hi     = 0;
  endfunction

  // Element at pos enters the window
  function automatic void add_at(int unsigned pos);
    int unsigned v;
    int unsigned b;
    v = elem_mem[pos % SIZE] % VALUES;
    b = occ_of[v];
    occ_of[v] = b + 1;
    if (b < SIZE) above_cnt[b] += 1;
  endfunction

  // Element at pos leaves the window; counts never go below zero
  function automatic void drop_at(int unsigned pos);
    int unsigned v;
    int unsigned b;
    v = elem_mem[pos % SIZE] % VALUES;
    b = occ_of[v];
    if (b == 0) return;
    occ_of[v] = b - 1;
    if (b - 1 < SIZE && above_cnt[b-1] > 0) above_cnt[b-1] -= 1;
  endfunction

  // Slide the window onto [lft, rgt] and count values seen 1..lim times
  function automatic tally_t answer_query(int unsigned lft, int unsigned rgt, int unsigned lim);
    tally_t      t;
    int unsigned stop;
    int unsigned hi_part;
    t.bad   = 1'b0;
    t.count = '0;
    // bad range leaves the window alone
    if (lft > rgt || rgt >= stored_len) begin
      t.bad = 1'b1;
      return t;
    end
    stop = rgt + 1;
    // grow first, then shrink
    while (win_lo > lft) begin
      win_lo--;
      add_at(win_lo);
    end
    while (win_hi < stop) begin
      add_at(win_hi);
      win_hi++;
    end
    while (win_lo < lft) begin
      drop_at(win_lo);
      win_lo++;
    end
    while (win_hi > stop) begin
      win_hi--;
      drop_at(win_hi);
    end
    // limits of SIZE and up clamp to an empty upper part
    hi_part = (lim < SIZE) ? above_cnt[lim] : 0;
    t.count = COUNT_W'(above_cnt[0] - hi_part);
    return t;
  endfunction

  task automatic note_miss(string msg);
    miss_total++;
    if (miss_total <= 10) $display("[%0t] %s", $time, msg);
  endtask

  always @(posedge clk) begin : watch
    tally_t want;
    if (!rst_n) begin
      clear_model();
      tallies_due.delete();
    end else begin
      // result beat against the oldest expectation
      if (out_mon.valid && out_mon.ready) begin
        if (tallies_due.size() == 0) begin
          note_miss($sformatf("result beat with nothing due: count %0d bad %0b",
                              out_mon.distinct_count, out_mon.bad_range));
        end else begin
          want = tallies_due.pop_front();
          if (out_mon.distinct_count !== want.count || out_mon.bad_range !== want.bad)
            note_miss($sformatf("result mismatch: expected count %0d bad %0b, got count %0d bad %0b",
                                want.count, want.bad, out_mon.distinct_count,
                                out_mon.bad_range));
        end
      end
      // input beat updates the model
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.opcode)
          OP_LOAD: begin
            // a full store drops the element
            if (stored_len < SIZE) begin
              elem_mem[stored_len] = ELEM_W'(in_mon.element_value % VALUES);
              stored_len++;
            end
          end
          OP_QUERY: begin
            tallies_due.insert(tallies_due.size(),
                               answer_query(in_mon.range_left, in_mon.range_right,
                                            in_mon.occurrence_limit));
          end
          OP_RESTART: begin
            clear_model();
          end
          default: ;
        endcase
      end
    end
    pending  <= tallies_due.size();
    failures <= miss_total;
  end

endmodule

// ===== dv/tb_top.sv =====
// Test top for the range bounded frequency counter: clock, reset, stimulus and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rbfc_pkg::*;

  localparam int      SIZE         = 4096;
  localparam int      VALUES       = 1024;
  localparam int      PERIOD       = 20;
  localparam int      CYCLE_LIMIT  = 6_000_000;
  localparam int      SETTLE       = 4200;
  localparam int      RANDOM_BEATS = 950;
  localparam opcode_t OP_UNUSED    = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        steady = 1'b0;
  int          pending;
  int          failures;
  int unsigned fill = 0;
  int unsigned cycles = 0;

  rbfc_in_if  in_ch ();
  rbfc_out_if out_ch ();

  range_bounded_frequency_counter #(.SIZE(SIZE), .VALUES(VALUES)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rbfc_tally_checker #(.SIZE(SIZE), .VALUES(VALUES)) u_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_mon   (in_ch),
    .out_mon  (out_ch),
    .pending  (pending),
    .failures (failures)
  );

  always #(PERIOD/2) clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Gap length: mostly none or short, now and then long; none in steady stretches
  function automatic int idle_len();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: ready in random bursts with random stalls between
  initial begin : result_sink
    int n;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      n = idle_len();
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // One input beat; valid stays up across back-to-back beats
  task automatic send_beat(input opcode_t op, input logic [ELEM_W-1:0] v,
                           input logic [RANGE_W-1:0] l, input logic [RANGE_W-1:0] r,
                           input logic [LIMIT_W-1:0] lim);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.opcode           <= op;
    in_ch.element_value    <= v;
    in_ch.range_left       <= l;
    in_ch.range_right      <= r;
    in_ch.occurrence_limit <= lim;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // Beat that the block drops; all fields noise
  task automatic send_unused();
    send_beat(OP_UNUSED, ELEM_W'($urandom), RANGE_W'($urandom), RANGE_W'($urandom),
              LIMIT_W'($urandom));
  endtask

  // Unused fields carry noise
  task automatic load_elem(input int unsigned v);
    send_beat(OP_LOAD, ELEM_W'(v), RANGE_W'($urandom), RANGE_W'($urandom),
              LIMIT_W'($urandom));
    if (fill < SIZE) fill++;
  endtask

  task automatic ask_range(input int unsigned l, input int unsigned r, input int unsigned lim);
    send_beat(OP_QUERY, ELEM_W'($urandom), RANGE_W'(l), RANGE_W'(r), LIMIT_W'(lim));
  endtask

  task automatic restart_block();
    send_beat(OP_RESTART, ELEM_W'($urandom), RANGE_W'($urandom), RANGE_W'($urandom),
              LIMIT_W'($urandom));
    fill = 0;
  endtask

  initial begin : stimulus
    int unsigned pool [8];
    int unsigned pool_n;
    int unsigned n_loads;
    int unsigned n_queries;
    int unsigned a;
    int unsigned b;
    int unsigned kind;
    int unsigned lim;
    int unsigned lim_roll;
    int unsigned random_beats;
    bit          wide;

    rst_n                  <= 1'b0;
    in_ch.valid            <= 1'b0;
    in_ch.opcode           <= OP_LOAD;
    in_ch.element_value    <= '0;
    in_ch.range_left       <= '0;
    in_ch.range_right      <= '0;
    in_ch.occurrence_limit <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty store, unused opcode, small set with repeats, edge limits
    ask_range(0, 0, 1);
    send_unused();
    load_elem(0);
    load_elem(1023);
    load_elem(10'h2AA);
    load_elem(10'h155);
    load_elem(1023);
    load_elem(0);
    load_elem(5);
    load_elem(5);
    ask_range(0, 7, 0);
    ask_range(0, 7, 1);
    ask_range(0, 7, 2);
    ask_range(2, 5, SIZE);
    ask_range(7, 7, 8191);
    ask_range(5, 2, 1);
    ask_range(0, 8, 1);
    ask_range(3, 6, SIZE - 1);
    ask_range(0, 0, 1);
    restart_block();
    ask_range(0, 0, 1);
    load_elem(7);
    ask_range(0, 0, 1);

    // Full store, every other element the same value; the last two loads are dropped
    restart_block();
    for (int i = 0; i < SIZE + 2; i++) load_elem((i % 2 == 1) ? $urandom_range(0, 1023) : 0);
    ask_range(0, SIZE - 1, SIZE - 1);
    ask_range(SIZE - 1, SIZE - 1, 1);
    ask_range(0, SIZE - 1, SIZE);
    ask_range(2048, SIZE - 1, 8191);
    ask_range(0, 0, SIZE / 2);
    ask_range(0, SIZE - 1, SIZE / 2);
    ask_range(0, SIZE - 1, SIZE / 2 - 1);
    ask_range(100, 4000, 1);
    ask_range(SIZE - 1, 0, 1);

    // Random rounds: optional restart, a batch of loads, a batch of queries
    random_beats = 0;
    while (random_beats < RANDOM_BEATS) begin
      steady = ($urandom_range(0, 4) == 0);
      if (fill > 160 || $urandom_range(0, 3) != 0) begin
        restart_block();
        random_beats++;
      end
      // small pools give many repeats, wide mode spreads values
      wide   = ($urandom_range(0, 2) == 0);
      pool_n = $urandom_range(1, 6);
      foreach (pool[i]) pool[i] = $urandom_range(0, 1023);
      n_loads = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 96) : $urandom_range(1, 24);
      repeat (n_loads) begin
        load_elem(wide ? $urandom_range(0, 1023) : pool[$urandom_range(0, pool_n - 1)]);
        random_beats++;
      end
      n_queries = $urandom_range(4, 30);
      repeat (n_queries) begin
        kind     = $urandom_range(0, 9);
        a        = $urandom_range(0, fill - 1);
        b        = $urandom_range(0, fill - 1);
        lim_roll = $urandom_range(0, 9);
        if (lim_roll < 6) lim = $urandom_range(0, 4);
        else if (lim_roll < 9) lim = $urandom_range(0, fill + 1);
        else lim = $urandom_range(SIZE, 8191);
        if (kind == 0) begin
          // noise the block drops
          send_unused();
        end else if (kind == 1) begin
          // raw fields, mostly past the loaded length
          ask_range($urandom, $urandom, $urandom);
          random_beats++;
        end else if (kind == 2 && a != b) begin
          // left past right
          ask_range((a > b) ? a : b, (a > b) ? b : a, lim);
          random_beats++;
        end else begin
          ask_range((a < b) ? a : b, (a < b) ? b : a, lim);
          random_beats++;
        end
      end
    end

    // Drain and settle
    in_ch.valid <= 1'b0;
    steady = 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rbfc_pkg.sv
rtl/rbfc_if.sv
rtl/rbfc_ctrl.sv
rtl/rbfc_dpath.sv
rtl/range_bounded_frequency_counter.sv
dv/rbfc_tally_checker.sv
dv/tb_top.sv
